// ===== design/tmi_pkg.sv =====
package tmi_pkg;

    // result codes
    localparam logic [2:0] ST_LOADED    = 3'd0;
    localparam logic [2:0] ST_EXEC      = 3'd1;
    localparam logic [2:0] ST_OUT       = 3'd2;
    localparam logic [2:0] ST_NEED      = 3'd3;
    localparam logic [2:0] ST_END       = 3'd4;
    localparam logic [2:0] ST_RIGHT     = 3'd5;
    localparam logic [2:0] ST_LEFT      = 3'd6;
    localparam logic [2:0] ST_UNMATCHED = 3'd7;

    // request opcodes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_STEP    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // instruction characters
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_PUT   = 8'h2E;
    localparam logic [7:0] CH_GET   = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef enum logic [1:0] {
        K_LOAD,
        K_STEP,
        K_RESTART,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] prog_addr;
        logic [7:0]  prog_byte;
        logic        last_byte;
        logic        input_valid;
        logic [7:0]  input_byte;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_byte;
        logic [12:0] program_counter;
        logic [14:0] cell_pointer;
    } t_res;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCANF_RD,
        S_SCANF_CK,
        S_SCANB_RD,
        S_SCANB_CK
    } t_state;

endpackage

// ===== design/tmi_front.sv =====
module tmi_front #(
    parameter int PROG_DEPTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_opcode,
    input  logic [11:0]   i_prog_addr,
    input  logic [7:0]    i_prog_byte,
    input  logic          i_last_byte,
    input  logic          i_input_valid,
    input  logic [7:0]    i_input_byte,
    output logic          o_cmd_valid,
    output tmi_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import tmi_pkg::*;

    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       push;

    // classify: out-of-range loads and the spare opcode carry no work
    always_comb begin
        cls.prog_addr   = i_prog_addr;
        cls.prog_byte   = i_prog_byte;
        cls.last_byte   = i_last_byte;
        cls.input_valid = i_input_valid;
        cls.input_byte  = i_input_byte;
        unique case (i_opcode)
            OP_LOAD:    cls.kind = (32'(i_prog_addr) < 32'(PROG_DEPTH)) ? K_LOAD : K_NOP;
            OP_STEP:    cls.kind = K_STEP;
            OP_RESTART: cls.kind = K_RESTART;
            default:    cls.kind = K_NOP;
        endcase
    end

    assign o_ready     = (r_cnt != 2'(QD));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

// ===== design/tmi_back.sv =====
module tmi_back #(
    parameter int PROG_DEPTH = 4096,
    parameter int TAPE_DEPTH = 32768
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  tmi_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tmi_pkg::t_res o_out
);
    import tmi_pkg::*;

    localparam int AW = $clog2(PROG_DEPTH);
    localparam int PW = AW + 1;
    localparam int TW = $clog2(TAPE_DEPTH);

    logic [7:0] prog_mem [PROG_DEPTH];
    logic [7:0] tape_mem [TAPE_DEPTH];
    logic [7:0] r_prog_q, r_tape_q;

    t_state r_state, n_state;
    logic [PW-1:0] r_pc, n_pc, r_len, n_len, r_idx, n_idx, r_depth, n_depth;
    logic [TW-1:0] r_tp, n_tp, r_clr, n_clr;
    logic r_halted, n_halted;
    t_cmd r_cmd, n_cmd;
    logic r_out_valid, n_out_valid;
    t_res r_out, n_out;

    logic          p_we;
    logic [AW-1:0] p_wa, p_ra;
    logic          t_we;
    logic [TW-1:0] t_wa;
    logic [7:0]    t_wd;
    logic          emit;
    logic [2:0]    e_status;
    logic [7:0]    e_byte;

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            prog_mem[p_wa] <= i_cmd.prog_byte;
        end
        r_prog_q <= prog_mem[p_ra];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            tape_mem[t_wa] <= t_wd;
        end
        r_tape_q <= tape_mem[r_tp];
    end

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_len       = r_len;
        n_idx       = r_idx;
        n_depth     = r_depth;
        n_tp        = r_tp;
        n_clr       = r_clr;
        n_halted    = r_halted;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !i_out_ready;
        o_pop       = 1'b0;
        p_we        = 1'b0;
        p_wa        = AW'(i_cmd.prog_addr);
        p_ra        = AW'(r_pc);
        t_we        = 1'b0;
        t_wa        = r_tp;
        t_wd        = 8'd0;
        emit        = 1'b0;
        e_status    = ST_EXEC;
        e_byte      = 8'd0;
        unique case (r_state)
            S_CLEAR: begin
                t_we  = 1'b1;
                t_wa  = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == TW'(TAPE_DEPTH - 1)) begin
                    n_clr   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && (!r_out_valid || i_out_ready)) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    unique case (i_cmd.kind)
                        K_LOAD: begin
                            p_we = 1'b1;
                            if (i_cmd.last_byte) begin
                                n_len = PW'(i_cmd.prog_addr) + 1'b1;
                            end
                            emit     = 1'b1;
                            e_status = ST_LOADED;
                        end
                        K_RESTART: begin
                            n_pc     = '0;
                            n_tp     = '0;
                            n_halted = 1'b0;
                            n_state  = S_CLEAR;
                            emit     = 1'b1;
                            e_status = ST_LOADED;
                        end
                        K_STEP: begin
                            if (r_halted || r_pc >= r_len) begin
                                emit     = 1'b1;
                                e_status = ST_END;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                        default: begin
                            emit     = 1'b1;
                            e_status = ST_LOADED;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                emit    = 1'b1;
                n_state = S_IDLE;
                n_pc    = r_pc + 1'b1;
                case (r_prog_q) inside
                    CH_INC, CH_DEC: begin
                        t_we = 1'b1;
                        t_wd = (r_prog_q == CH_INC) ? r_tape_q + 8'd1 : r_tape_q - 8'd1;
                    end
                    CH_RIGHT: begin
                        if (r_tp == TW'(TAPE_DEPTH - 1)) begin
                            n_pc     = r_pc;
                            n_halted = 1'b1;
                            e_status = ST_RIGHT;
                        end else begin
                            n_tp = r_tp + 1'b1;
                        end
                    end
                    CH_LEFT: begin
                        if (r_tp == '0) begin
                            n_pc     = r_pc;
                            n_halted = 1'b1;
                            e_status = ST_LEFT;
                        end else begin
                            n_tp = r_tp - 1'b1;
                        end
                    end
                    CH_PUT: begin
                        e_status = ST_OUT;
                        e_byte   = r_tape_q;
                    end
                    CH_GET: begin
                        if (!r_cmd.input_valid) begin
                            n_pc     = r_pc;
                            e_status = ST_NEED;
                        end else begin
                            t_we = 1'b1;
                            t_wd = r_cmd.input_byte;
                        end
                    end
                    CH_OPEN: begin
                        if (r_tape_q == 8'd0) begin
                            emit    = 1'b0;
                            n_pc    = r_pc;
                            n_idx   = r_pc + 1'b1;
                            n_depth = '0;
                            n_state = S_SCANF_RD;
                        end
                    end
                    CH_CLOSE: begin
                        if (r_tape_q != 8'd0) begin
                            emit    = 1'b0;
                            n_pc    = r_pc;
                            n_idx   = r_pc;
                            n_depth = '0;
                            n_state = S_SCANB_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCANF_RD: begin
                p_ra = AW'(r_idx);
                if (r_idx >= r_len) begin
                    emit     = 1'b1;
                    n_halted = 1'b1;
                    e_status = ST_UNMATCHED;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SCANF_CK;
                end
            end
            S_SCANF_CK: begin
                n_idx   = r_idx + 1'b1;
                n_state = S_SCANF_RD;
                if (r_prog_q == CH_OPEN) begin
                    n_depth = r_depth + 1'b1;
                end else if (r_prog_q == CH_CLOSE) begin
                    if (r_depth == '0) begin
                        n_pc    = r_idx + 1'b1;
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_depth = r_depth - 1'b1;
                    end
                end
            end
            S_SCANB_RD: begin
                p_ra = AW'(r_idx - 1'b1);
                if (r_idx == '0) begin
                    emit     = 1'b1;
                    n_halted = 1'b1;
                    e_status = ST_UNMATCHED;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_SCANB_CK;
                end
            end
            S_SCANB_CK: begin
                n_state = S_SCANB_RD;
                if (r_prog_q == CH_CLOSE) begin
                    n_depth = r_depth + 1'b1;
                end else if (r_prog_q == CH_OPEN) begin
                    if (r_depth == '0) begin
                        n_pc    = r_idx;
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_depth = r_depth - 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out = r_out;
        if (emit) begin
            n_out_valid           = 1'b1;
            n_out.status          = e_status;
            n_out.out_byte        = e_byte;
            n_out.program_counter = 13'(n_pc);
            n_out.cell_pointer    = 15'(n_tp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pc        <= '0;
            r_len       <= '0;
            r_tp        <= '0;
            r_clr       <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_depth     <= '0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_len       <= n_len;
            r_tp        <= n_tp;
            r_clr       <= n_clr;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_depth     <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop) else $error("request taken during tape clear");
    a_clear_rewound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (r_tp == '0 && r_pc == '0 && !r_halted))
        else $error("clear pass without rewind");
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_out_valid || i_out_ready)) else $error("result slot overrun");
    a_byte_only_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OUT) |-> (r_out.out_byte == 8'd0))
        else $error("stray output byte");

endmodule

// ===== design/tape_machine_interpreter.sv =====
// Channel   Dir  Handshake                      Contents
// s_axis    in   s_axis_tvalid/s_axis_tready    one request: load, step or restart
// m_axis    out  m_axis_tvalid/m_axis_tready    one result for every request
//
// A load, restart or dud request gives its result in the cycle after it leaves the queue;
// a plain step reads program and tape, then writes the tape back and gives its result.
// A bracket jump adds a read state and a check state for every program byte the match search scans.
// Reset and every restart run a tape clearing pass over all TAPE_DEPTH cells (32768 by
// default), one cell a cycle; requests queue up but are held until it ends.
// A two-entry queue parts the front from the executor and keeps taking requests while a
// result waits on m_axis_tready, until it fills; the executor holds until the result register drains.
module tape_machine_interpreter #(
    parameter int PROG_DEPTH = 4096,
    parameter int TAPE_DEPTH = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // prog_addr[11:0], prog_byte[19:12], input_byte[27:20]
    input  logic [2:0]  s_axis_tuser,  // opcode[1:0], input_valid[2]
    input  logic        s_axis_tlast,  // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_byte[7:0], program_counter[20:8], cell_pointer[35:21]
    output logic [2:0]  m_axis_tuser   // status[2:0]
);
    import tmi_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic pop;
    t_res res;

    // front: take requests, sort by kind, hold them in the queue
    tmi_front #(
        .PROG_DEPTH(PROG_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_opcode      (s_axis_tuser[1:0]),
        .i_prog_addr   (s_axis_tdata[11:0]),
        .i_prog_byte   (s_axis_tdata[19:12]),
        .i_last_byte   (s_axis_tlast),
        .i_input_valid (s_axis_tuser[2]),
        .i_input_byte  (s_axis_tdata[27:20]),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_pop         (pop)
    );

    // back: program store, tape and the step sequencer
    tmi_back #(
        .PROG_DEPTH(PROG_DEPTH),
        .TAPE_DEPTH(TAPE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res)
    );

    // pack the result, zero fill to whole bytes
    assign m_axis_tdata = {4'd0, res.cell_pointer, res.program_counter, res.out_byte};
    assign m_axis_tuser = res.status;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import tmi_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // prog_addr[11:0], prog_byte[19:12], input_byte[27:20]
    logic [2:0]  s_axis_tuser;   // opcode[1:0], input_valid[2]
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // out_byte[7:0], program_counter[20:8], cell_pointer[35:21]
    logic [2:0]  m_axis_tuser;   // status[2:0]

    tape_machine_interpreter uut (.*);

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // machine state as the testbench sees it
    bit [7:0]    tape_mem [32768];
    bit [7:0]    prog_mem [4096];
    int unsigned prog_len, pc_r, tp_r;
    bit          halted_r;

    t_res        expected_q [$];
    int          errors;
    int          quiet_cycles;
    int          restarts_left;
    bit          no_idle;
    bit          hold_req;

    function automatic t_res model_request(logic [1:0] op, logic [11:0] addr, logic [7:0] pb,
                                           logic last, logic iv, logic [7:0] ib);
        t_res        r;
        logic [7:0]  c;
        int          depth;
        int          i;
        int          hit;
        r.status   = ST_LOADED;
        r.out_byte = 8'd0;
        if (op == OP_LOAD) begin
            prog_mem[addr] = pb;
            if (last) prog_len = addr + 1;
        end else if (op == OP_RESTART) begin
            foreach (tape_mem[k]) tape_mem[k] = 8'd0;
            tp_r = 0; pc_r = 0; halted_r = 1'b0;
        end else if (op == OP_STEP) begin
            if (halted_r || pc_r >= prog_len) begin
                r.status = ST_END;
            end else begin
                c = prog_mem[pc_r];
                r.status = ST_EXEC;
                case (c)
                    CH_INC: tape_mem[tp_r]++;
                    CH_DEC: tape_mem[tp_r]--;
                    CH_RIGHT: if (tp_r == 32767) r.status = ST_RIGHT; else tp_r++;
                    CH_LEFT:  if (tp_r == 0) r.status = ST_LEFT; else tp_r--;
                    CH_PUT: begin
                        r.out_byte = tape_mem[tp_r];
                        r.status   = ST_OUT;
                    end
                    CH_GET: if (!iv) r.status = ST_NEED; else tape_mem[tp_r] = ib;
                    CH_OPEN: if (tape_mem[tp_r] == 0) begin
                        // search forward for the partner, counting nested pairs
                        depth = 0; hit = -1;
                        for (i = pc_r + 1; i < prog_len && hit < 0; i++) begin
                            if (prog_mem[i] == CH_OPEN) depth++;
                            else if (prog_mem[i] == CH_CLOSE) begin
                                if (depth == 0) hit = i; else depth--;
                            end
                        end
                        if (hit < 0) r.status = ST_UNMATCHED; else pc_r = hit;
                    end
                    CH_CLOSE: if (tape_mem[tp_r] != 0) begin
                        depth = 0; hit = -1;
                        for (i = pc_r - 1; i >= 0 && hit < 0; i--) begin
                            if (prog_mem[i] == CH_CLOSE) depth++;
                            else if (prog_mem[i] == CH_OPEN) begin
                                if (depth == 0) hit = i; else depth--;
                            end
                        end
                        // land on the opening bracket itself: it is evaluated again
                        if (hit < 0) r.status = ST_UNMATCHED; else pc_r = hit - 1;
                    end
                    default: ;
                endcase
                if (r.status inside {ST_RIGHT, ST_LEFT, ST_UNMATCHED}) halted_r = 1'b1;
                else if (r.status != ST_NEED) pc_r++;
            end
        end
        r.program_counter = pc_r[12:0];
        r.cell_pointer    = tp_r[14:0];
        return r;
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_req(logic [1:0] op, logic [11:0] addr = 0, logic [7:0] pb = 0,
                            logic last = 0, logic iv = 0, logic [7:0] ib = 0);
        t_res r;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'd0, ib, pb, addr};
        s_axis_tuser  = {iv, op};
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        r = model_request(op, addr, pb, last, iv, ib);
        expected_q.push_back(r);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
        end
    endtask

    task automatic load_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_req(OP_LOAD, i[11:0], s[i], i == s.len() - 1);
    endtask

    task automatic step(int n);
        repeat (n) send_req(OP_STEP, 0, 0, 0, 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255)));
    endtask

    // drop the offer, then wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (expected_q.size() == 0);
    endtask

    // every instruction but ']', missing input, foreign byte, left edge, halted, program end
    task automatic test_directed();
        send_req(OP_LOAD, 12'hFFF, 8'hFF, 1'b0);
        load_text("a-.,>[-]<<");
        step(3);
        send_req(OP_STEP, 0, 0, 0, 1'b0, 8'h00);
        send_req(OP_STEP, 0, 0, 0, 1'b1, 8'hFF);
        step(6);
        send_req(OP_UNUSED, 12'hFFF, 8'hFF, 1'b1, 1'b1, 8'hFF);
        send_req(OP_RESTART);
        load_text("+");
        step(2);
        drain();
    endtask

    // a bracket with no partner on either side
    task automatic test_unmatched();
        load_text("[");
        step(2);
        send_req(OP_RESTART);
        load_text("+]");
        step(3);
        send_req(OP_RESTART);
        drain();
    endtask

    task automatic test_random();
        int         items;
        int         len;
        int         opened;
        int         n_steps;
        string      s;
        byte        tokens [10];
        tokens = '{"+", "-", ">", ">", "<", ".", ",", "[", "]", "x"};
        items = 0;
        while (items < 800) begin
            if (items > 650) no_idle = 1'b1;
            if (items > 100 && items < 130) hold_req = 1'b1;
            // a program of random tokens, brackets mostly paired
            len = $urandom_range(3, 12);
            s = ">";
            opened = 0;
            for (int i = 1; i < len; i++) begin
                s = {s, string'(tokens[$urandom_range(0, 9)])};
                if (s[i] == "[") opened++;
                if (s[i] == "]") begin
                    if (opened > 0 || $urandom_range(0, 9) == 0) opened--;
                    else s[i] = "+";
                end
            end
            while (opened > 0 && $urandom_range(0, 9) != 0) begin
                s = {s, "]"};
                opened--;
            end
            load_text(s);
            items += s.len();
            if ($urandom_range(0, 3) == 0) begin
                send_req(OP_LOAD, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                         1'b0);
                items++;
            end
            n_steps = $urandom_range(5, 3 * s.len());
            step(n_steps);
            items += n_steps;
            if ($urandom_range(0, 7) == 0) begin
                send_req(OP_UNUSED, 12'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                         8'($urandom));
                items++;
            end
            if (halted_r && restarts_left > 0) begin
                restarts_left--;
                send_req(OP_RESTART);
                items++;
            end
            if ($urandom_range(0, 9) == 0) drain();
        end
    endtask

    // receiver: random back-pressure, plus long hold-offs on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (80) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_res exp_r;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (m_axis_tuser != exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[7:0] != exp_r.out_byte) begin
                    $error("out_byte exp %0d got %0d", exp_r.out_byte, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[20:8] != exp_r.program_counter) begin
                    $error("program_counter exp %0d got %0d", exp_r.program_counter,
                           m_axis_tdata[20:8]);
                    errors++;
                end
                if (m_axis_tdata[35:21] != exp_r.cell_pointer) begin
                    $error("cell_pointer exp %0d got %0d", exp_r.cell_pointer,
                           m_axis_tdata[35:21]);
                    errors++;
                end
            end
        end
    end

    // watchdog: allow well beyond a full tape clearing pass
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 150000) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        errors        = 0;
        quiet_cycles  = 0;
        restarts_left = 4;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        prog_len = 0; pc_r = 0; tp_r = 0; halted_r = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_unmatched();
        test_random();

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
